### sv/lobm_pkg.sv
package lobm_pkg;

    localparam int BOOK_DEPTH = 16;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_BID   = 2'd0,
        ACT_ASK   = 2'd1,
        ACT_MATCH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_TRADE    = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_ZERO_QTY = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_REPORT   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MATCH,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load;     // capture input request
        logic    insert;   // insert captured order
        logic    trade;    // cross best bid and best ask
        logic    set_out;  // load result register
        kind_t   kind;
        logic    last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    qty_zero;
        logic    book_full;
        logic    crossing;
        action_t action;
    } status_t;

endpackage

### sv/lobm_book.sv
module lobm_book
    import lobm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                is_bid,
    input  logic                insert,
    input  logic [31:0]         ins_price,
    input  logic [31:0]         ins_qty,
    input  logic                dec,
    input  logic [31:0]         dec_qty,
    output logic [31:0]         top_price,
    output logic [31:0]         top_qty,
    output logic                present,
    output logic                full
);

    logic [31:0]      price_reg [BOOK_DEPTH];
    logic [31:0]      qty_reg   [BOOK_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [BOOK_DEPTH-1:0] after;
    logic [31:0]      rem;
    logic             pop;

    assign top_price = price_reg[0];
    assign top_qty   = qty_reg[0];
    assign present   = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(BOOK_DEPTH));
    assign rem       = qty_reg[0] - dec_qty;
    assign pop       = dec && (rem == '0);

    // a cell lies after the new order when it is not valid or ranks strictly worse
    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (CNT_W'(i) >= count_reg)
                after[i] = 1'b1;
            else if (is_bid)
                after[i] = price_reg[i] < ins_price;
            else
                after[i] = price_reg[i] > ins_price;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (insert) begin
                if (after[i]) begin
                    if (i == 0 || !after[(i == 0) ? 0 : i-1]) begin
                        price_reg[i] <= ins_price;
                        qty_reg[i]   <= ins_qty;
                    end else begin
                        price_reg[i] <= price_reg[(i == 0) ? 0 : i-1];
                        qty_reg[i]   <= qty_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (pop) begin
                if (i < BOOK_DEPTH-1) begin
                    price_reg[i] <= price_reg[(i < BOOK_DEPTH-1) ? i+1 : i];
                    qty_reg[i]   <= qty_reg[(i < BOOK_DEPTH-1) ? i+1 : i];
                end
            end else if (dec && i == 0) begin
                qty_reg[0] <= rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (insert) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (pop) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### sv/lobm_datapath.sv
module lobm_datapath
    import lobm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output status_t      status,
    input  logic [65:0]  in_data,
    input  logic [31:0]  base_tick,
    output logic [165:0] out_data
);

    action_t     action_reg;
    logic [31:0] price_reg, qty_reg;
    logic [31:0] last_reg;
    logic        traded_reg;

    logic [31:0] bp, bq, ap, aq, tq;
    logic        bpres, apres, bfull, afull;

    logic [165:0] out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= action_t'(in_data[1:0]);
            price_reg  <= in_data[33:2];
            qty_reg    <= in_data[65:34];
        end
    end

    assign tq = (bq < aq) ? bq : aq;

    lobm_book u_bid (
        .aclk(aclk), .aresetn(aresetn), .is_bid(1'b1),
        .insert(cmd.insert && action_reg == ACT_BID),
        .ins_price(price_reg), .ins_qty(qty_reg),
        .dec(cmd.trade), .dec_qty(tq),
        .top_price(bp), .top_qty(bq), .present(bpres), .full(bfull)
    );

    lobm_book u_ask (
        .aclk(aclk), .aresetn(aresetn), .is_bid(1'b0),
        .insert(cmd.insert && action_reg == ACT_ASK),
        .ins_price(price_reg), .ins_qty(qty_reg),
        .dec(cmd.trade), .dec_qty(tq),
        .top_price(ap), .top_qty(aq), .present(apres), .full(afull)
    );

    assign status.qty_zero  = (qty_reg == '0);
    assign status.book_full = (action_reg == ACT_BID) ? bfull : afull;
    assign status.crossing  = bpres && apres && (bp >= ap);
    assign status.action    = action_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            traded_reg <= 1'b0;
            last_reg   <= '0;
        end else if (cmd.trade) begin
            traded_reg <= 1'b1;
            last_reg   <= ap;
        end
    end

    // fields from bit 0: kind, trade_price, trade_qty, top_bid, bid_present,
    // top_ask, ask_present, last_price, last_of_run
    always_comb begin
        out_next = '0;
        out_next[2:0] = cmd.kind;
        if (cmd.kind == KIND_TRADE) begin
            out_next[34:3]  = ap;
            out_next[66:35] = tq;
        end
        if (cmd.kind == KIND_REPORT) begin
            out_next[98:67]   = bpres ? bp : 32'd0;
            out_next[99]      = bpres;
            out_next[131:100] = apres ? ap : 32'd0;
            out_next[132]     = apres;
            out_next[164:133] = traded_reg ? last_reg : base_tick;
        end
        out_next[165] = cmd.last;
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_out) out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

### sv/lobm_ctrl.sv
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   free;

    assign free    = !mv_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.kind   = KIND_REPORT;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.action == ACT_NONE) begin
                    state_next = ST_IDLE;
                end else if (status.action == ACT_MATCH) begin
                    state_next = ST_MATCH;
                end else if (free) begin
                    cmd.set_out = 1'b1;
                    cmd.last    = 1'b1;
                    mv_next     = 1'b1;
                    if (status.qty_zero) begin
                        cmd.kind = KIND_ZERO_QTY;
                    end else if (status.book_full) begin
                        cmd.kind = KIND_FULL;
                    end else begin
                        cmd.kind   = KIND_ACCEPTED;
                        cmd.insert = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH: begin
                if (free) begin
                    cmd.set_out = 1'b1;
                    mv_next     = 1'b1;
                    if (status.crossing) begin
                        cmd.kind  = KIND_TRADE;
                        cmd.trade = 1'b1;
                    end else begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/limit_order_book_matcher_unit.sv
// Limit order book matcher: sorted bid and ask books of BOOK_DEPTH cells each.
// Flow: an add request is captured, then inserted and its result loaded in ST_EXEC
// once the output is free; a match is captured, passes ST_EXEC, then ST_MATCH
// gives one result per cycle (trades, then the price report) while m_tready is high.
// s_tready is high only in ST_IDLE: no request is taken until the last is done;
// a held result stalls the next step.
// Reset: synchronous active-low aresetn empties both books, clears last trade
// and the base price; book cells themselves are not cleared.
module limit_order_book_matcher_unit
    import lobm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // action[1:0], order_price[33:2], order_qty[65:34]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // kind, trade_price, trade_qty, top_bid,
                                    // bid_present, top_ask, ask_present, last_price
    output logic         m_tlast    // last_of_run
);

    logic [31:0]  base_reg;
    cmd_t         cmd;
    status_t      status;
    logic [165:0] out_data;

    // hold base price until rewritten
    always_ff @(posedge aclk) begin
        if (!aresetn) base_reg <= '0;
        else if (cfg_we) base_reg <= cfg_wdata;
    end

    lobm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .status(status), .cmd(cmd)
    );

    lobm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .in_data(s_tdata[65:0]), .base_tick(base_reg),
        .out_data(out_data)
    );

    assign m_tdata = {3'd0, out_data[164:0]};
    assign m_tlast = out_data[165];

endmodule

### tb/limit_order_book_matcher_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the books and compares every result.
module limit_order_book_matcher_unit_checker
    import lobm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           trades_seen,
    output int           reports_seen
);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [31:0] top_bid;
        logic        bid_present;
        logic [31:0] top_ask;
        logic        ask_present;
        logic [31:0] last_price;
        logic        last;
    } book_result_t;

    logic [31:0] bid_px [$];
    logic [31:0] bid_qt [$];
    logic [31:0] ask_px [$];
    logic [31:0] ask_qt [$];
    logic [31:0] last_trade_px;
    logic        traded;
    logic [31:0] base_px;
    book_result_t expected_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic book_result_t blank_result(kind_t k, logic lst);
        book_result_t r;
        r = '0;
        r.kind = k;
        r.last = lst;
        return r;
    endfunction

    // Apply one request to the model books and queue what it must produce.
    task automatic predict_book(input logic [71:0] req);
        action_t     act;
        logic [31:0] px;
        logic [31:0] qt;
        logic [31:0] tq;
        book_result_t r;
        int pos;
        act = action_t'(req[1:0]);
        px  = req[33:2];
        qt  = req[65:34];
        if (act == ACT_BID || act == ACT_ASK) begin
            if (qt == 0) begin
                r = blank_result(KIND_ZERO_QTY, 1'b1);
            end else if (act == ACT_BID && bid_px.size() >= BOOK_DEPTH) begin
                r = blank_result(KIND_FULL, 1'b1);
            end else if (act == ACT_ASK && ask_px.size() >= BOOK_DEPTH) begin
                r = blank_result(KIND_FULL, 1'b1);
            end else begin
                // equal prices queue behind older ones
                pos = 0;
                if (act == ACT_BID) begin
                    while (pos < bid_px.size() && bid_px[pos] >= px) pos++;
                    bid_px.insert(pos, px);
                    bid_qt.insert(pos, qt);
                end else begin
                    while (pos < ask_px.size() && ask_px[pos] <= px) pos++;
                    ask_px.insert(pos, px);
                    ask_qt.insert(pos, qt);
                end
                r = blank_result(KIND_ACCEPTED, 1'b1);
            end
            expected_results.push_back(r);
        end else if (act == ACT_MATCH) begin
            while (bid_px.size() > 0 && ask_px.size() > 0 && bid_px[0] >= ask_px[0]) begin
                tq = (bid_qt[0] < ask_qt[0]) ? bid_qt[0] : ask_qt[0];
                r = blank_result(KIND_TRADE, 1'b0);
                r.trade_price = ask_px[0];
                r.trade_qty = tq;
                last_trade_px = ask_px[0];
                traded = 1'b1;
                expected_results.push_back(r);
                bid_qt[0] = bid_qt[0] - tq;
                ask_qt[0] = ask_qt[0] - tq;
                if (bid_qt[0] == 0) begin
                    void'(bid_px.pop_front());
                    void'(bid_qt.pop_front());
                end
                if (ask_qt[0] == 0) begin
                    void'(ask_px.pop_front());
                    void'(ask_qt.pop_front());
                end
            end
            r = blank_result(KIND_REPORT, 1'b1);
            r.bid_present = bid_px.size() > 0;
            r.top_bid = r.bid_present ? bid_px[0] : '0;
            r.ask_present = ask_px.size() > 0;
            r.top_ask = r.ask_present ? ask_px[0] : '0;
            r.last_price = traded ? last_trade_px : base_px;
            expected_results.push_back(r);
        end
    endtask

    task automatic check_result();
        book_result_t want;
        if (expected_results.size() == 0) begin
            $display("[%0t] unexpected result, kind %0d", $time, m_tdata[2:0]);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (m_tdata[2:0] != want.kind) report_mismatch("kind", m_tdata[2:0], want.kind);
            if (m_tdata[34:3] != want.trade_price)
                report_mismatch("trade_price", m_tdata[34:3], want.trade_price);
            if (m_tdata[66:35] != want.trade_qty)
                report_mismatch("trade_qty", m_tdata[66:35], want.trade_qty);
            if (m_tdata[98:67] != want.top_bid)
                report_mismatch("top_bid", m_tdata[98:67], want.top_bid);
            if (m_tdata[99] != want.bid_present)
                report_mismatch("bid_present", m_tdata[99], want.bid_present);
            if (m_tdata[131:100] != want.top_ask)
                report_mismatch("top_ask", m_tdata[131:100], want.top_ask);
            if (m_tdata[132] != want.ask_present)
                report_mismatch("ask_present", m_tdata[132], want.ask_present);
            if (m_tdata[164:133] != want.last_price)
                report_mismatch("last_price", m_tdata[164:133], want.last_price);
            if (m_tlast != want.last) report_mismatch("last_of_run", m_tlast, want.last);
            if (want.kind == KIND_TRADE) trades_seen++;
            if (want.kind == KIND_REPORT) reports_seen++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        trades_seen = 0;
        reports_seen = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            bid_px.delete();
            bid_qt.delete();
            ask_px.delete();
            ask_qt.delete();
            expected_results.delete();
            last_trade_px = '0;
            traded = 1'b0;
            base_px = '0;
        end else begin
            if (cfg_we) base_px = cfg_wdata;
            // check first: a result can never come from a request in the same edge
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) predict_book(s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

### tb/limit_order_book_matcher_unit_tb.sv
`timescale 1ns / 100ps

module limit_order_book_matcher_unit_tb;
    import lobm_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           trades_seen;
    int           reports_seen;
    int           requests_sent;
    int           quiet_cycles;

    limit_order_book_matcher_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    limit_order_book_matcher_unit_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .trades_seen  (trades_seen),
        .reports_seen (reports_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: stall the receiver at random, in its own process.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = gap_length();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Watchdog: count cycles in which neither channel moves a request or result.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("** limit_order_book_matcher_unit: FAILED **");
                $finish;
            end
        end
    end

    // Send one request and hold it until the block takes it; then idle for a random gap.
    task automatic send_request(input action_t act, input logic [31:0] px,
                                input logic [31:0] qt);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, qt, px, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait until every queued result is out and the block is idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || m_tvalid || !s_tready) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_base_price(input logic [31:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Prices cluster around a centre so books cross often.
    function automatic logic [31:0] near_price(input logic [31:0] centre);
        return centre + $urandom_range(0, 20) - 10;
    endfunction

    function automatic logic [31:0] random_qty();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 80) return $urandom_range(1, 50);
        return $urandom();
    endfunction

    initial begin
        logic [31:0] centre;
        int roll;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        requests_sent = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: report on empty books with base price at reset value.
        send_request(ACT_MATCH, 32'd0, 32'd0);
        write_base_price(32'hFFFF_FFFF);
        send_request(ACT_MATCH, 32'd0, 32'd0);
        // zero quantity is rejected on both sides
        send_request(ACT_BID, 32'd100, 32'd0);
        send_request(ACT_ASK, 32'hFFFF_FFFF, 32'd0);
        // extremes of price and quantity
        send_request(ACT_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_ASK, 32'd0, 32'hFFFF_FFFF);
        send_request(ACT_ASK, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(ACT_BID, 32'hAAAA_AAAA, 32'h5555_5555);
        // unused action code must be ignored
        send_request(ACT_NONE, 32'h1234_5678, 32'd7);
        send_request(ACT_MATCH, 32'd0, 32'd0);
        // fill the bid book, equal prices, then one more for the full case
        repeat (16) send_request(ACT_BID, 32'd50, 32'd3);
        send_request(ACT_BID, 32'd60, 32'd1);
        send_request(ACT_ASK, 32'd50, 32'd100);
        send_request(ACT_MATCH, 32'd0, 32'd0);
        write_base_price(32'd0);

        // Random phases, each with its own base price and price centre.
        for (int phase = 0; phase < 4; phase++) begin
            write_base_price(phase == 3 ? 32'hFFFF_FFFF : $urandom());
            centre = (phase == 1) ? 32'd10 : (phase == 2) ? 32'hFFFF_FFF0 : $urandom();
            for (int n = 0; n < 75; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    send_request(ACT_BID, roll < 3 ? $urandom() : near_price(centre),
                                 random_qty());
                else if (roll < 80)
                    send_request(ACT_ASK, roll < 43 ? $urandom() : near_price(centre),
                                 random_qty());
                else if (roll < 97)
                    send_request(ACT_MATCH, $urandom(), $urandom());
                else
                    send_request(ACT_NONE, $urandom(), $urandom());
            end
            send_request(ACT_MATCH, 32'd0, 32'd0);
        end

        drain_results();
        $display("sent %0d requests; checked %0d trades and %0d price reports",
                 requests_sent, trades_seen, reports_seen);
        $display("covered empty and full books, zero quantity, price extremes, base prices");
        if (fail_count == 0) begin
            $display("** limit_order_book_matcher_unit: PASSED **");
        end else begin
            $display("** limit_order_book_matcher_unit: FAILED **");
        end
        $finish;
    end

    // catch leftovers is handled by drain: pending must reach zero or the watchdog fires

endmodule

### sim.f
sv/lobm_pkg.sv
sv/lobm_book.sv
sv/lobm_datapath.sv
sv/lobm_ctrl.sv
sv/limit_order_book_matcher_unit.sv
tb/limit_order_book_matcher_unit_checker.sv
tb/limit_order_book_matcher_unit_tb.sv
